// File: hdl/k_way_time_merge_assert.svh
// ----------------------------------------------------------------------------
// k_way_time_merge_assert.svh
// Assertion macros shared by the merge block. Every macro samples on the
// rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef K_WAY_TIME_MERGE_ASSERT_SVH
`define K_WAY_TIME_MERGE_ASSERT_SVH

// The antecedent must be followed by the consequent in the same cycle.
`define KWTM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent must be followed by the consequent in the next cycle.
`define KWTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/kwtm_pkg.sv
// ----------------------------------------------------------------------------
// kwtm_pkg
// Beat formats and codes of the k-way time merge.
// ----------------------------------------------------------------------------
package kwtm_pkg;

    localparam int LANE_FIELD_W = 3;
    localparam int TIME_FIELD_W = 32;
    localparam int ID_FIELD_W   = 16;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } kwtm_op_t;

    typedef enum logic [1:0]
    {
        ST_PUSH_OK   = 2'd0,
        ST_PUSH_DROP = 2'd1,
        ST_POPPED    = 2'd2,
        ST_EMPTY     = 2'd3
    } kwtm_status_t;

    typedef struct packed
    {
        kwtm_op_t                  operation;
        logic [LANE_FIELD_W-1:0]   lane;
        logic [TIME_FIELD_W-1:0]   timestamp;
        logic [ID_FIELD_W-1:0]     record_id;
    } kwtm_in_t;

    typedef struct packed
    {
        kwtm_status_t              status;
        logic [LANE_FIELD_W-1:0]   out_lane;
        logic [TIME_FIELD_W-1:0]   out_timestamp;
        logic [ID_FIELD_W-1:0]     out_record_id;
    } kwtm_out_t;

endpackage

// File: hdl/kwtm_ram.sv
// ----------------------------------------------------------------------------
// kwtm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kwtm_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/k_way_time_merge.sv
// ----------------------------------------------------------------------------
// k_way_time_merge
// Merges per-lane time-ordered FIFOs into one oldest-first stream.
//
// Input channel (in_valid/in_ready/in_data): a push beat appends a timestamp
// and record handle to the FIFO of one lane; a pop beat removes the oldest
// head over all lanes, the lowest lane winning a tie. Output channel
// (out_valid/out_ready/out_data): exactly one result beat per input beat,
// carrying a status and, for a pop, the record and its lane.
// The block takes one beat at a time. A push passes through S_PUSH to S_RESULT,
// or goes straight to S_RESULT when its lane index is not below LANES and it is
// dropped at once. A pop walks the lane heads with one shared comparator, one
// lane per cycle behind a two-stage read of lane state RAM and record RAM, then
// updates the chosen lane in S_POP_WR before it reaches S_RESULT.
// The result sits in an output register; a new beat is accepted while it
// waits, but the next result is held back until out_ready takes the old one.
// Reset clears all lane counters through per-lane valid bits; the record RAM
// needs no clearing, so the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "k_way_time_merge_assert.svh"

module k_way_time_merge
    import kwtm_pkg::*;
#(
    parameter int LANES      = 8,
    parameter int LANE_DEPTH = 16,
    parameter int TIME_BITS  = 32,
    parameter int ID_BITS    = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  kwtm_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output kwtm_out_t out_data
);

    localparam int LIDX_W      = $clog2(LANES);
    localparam int ISS_W       = $clog2(LANES + 1);
    localparam int PTR_W       = $clog2(LANE_DEPTH);
    localparam int CNT_W       = $clog2(LANE_DEPTH + 1);
    localparam int SUM_W       = PTR_W + 1;
    localparam int LST_W       = PTR_W + CNT_W;
    localparam int REC_W       = TIME_BITS + ID_BITS;
    localparam int STORE_DEPTH = LANES * (2 ** PTR_W);
    localparam int STORE_AW    = LIDX_W + PTR_W;
    localparam int LCMP_W      = (LIDX_W + 1 > LANE_FIELD_W) ? LIDX_W + 1 : LANE_FIELD_W;
    localparam int TEXT_W      = (TIME_BITS > TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;
    localparam int IEXT_W      = (ID_BITS > ID_FIELD_W) ? ID_BITS : ID_FIELD_W;

    typedef enum logic [4:0]
    {
        S_IDLE   = 5'b00001,
        S_PUSH   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_POP_WR = 5'b01000,
        S_RESULT = 5'b10000
    } kwtm_state_t;

    kwtm_state_t          state_reg, state_next;
    logic [LANES-1:0]     lane_valid_reg, lane_valid_next;
    logic [LIDX_W-1:0]    req_lane_reg, req_lane_next;
    logic [REC_W-1:0]     req_rec_reg, req_rec_next;
    logic [ISS_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 p1_vld_reg, p1_vld_next;
    logic [LIDX_W-1:0]    p1_lane_reg, p1_lane_next;
    logic                 p2_vld_reg, p2_vld_next;
    logic [LIDX_W-1:0]    p2_lane_reg, p2_lane_next;
    logic [PTR_W-1:0]     p2_rp_reg, p2_rp_next;
    logic [CNT_W-1:0]     p2_cnt_reg, p2_cnt_next;
    logic                 found_reg, found_next;
    logic [LIDX_W-1:0]    best_lane_reg, best_lane_next;
    logic [PTR_W-1:0]     best_rp_reg, best_rp_next;
    logic [CNT_W-1:0]     best_cnt_reg, best_cnt_next;
    logic [TIME_BITS-1:0] best_time_reg, best_time_next;
    logic [ID_BITS-1:0]   best_id_reg, best_id_next;
    kwtm_status_t         res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    kwtm_out_t            out_data_reg, out_data_next;

    // Lane state RAM: {read pointer, fill count} per lane.
    logic                 lst_we, lst_re;
    logic [LIDX_W-1:0]    lst_waddr, lst_raddr;
    logic [LST_W-1:0]     lst_wdata, lst_rdata;
    // Record RAM: {timestamp, handle} per slot.
    logic                 store_we, store_re;
    logic [STORE_AW-1:0]  store_waddr, store_raddr;
    logic [REC_W-1:0]     store_wdata, store_rdata;

    logic                 accept;
    logic [LCMP_W-1:0]    in_lane_ext;
    logic                 in_lane_ok;
    logic [TEXT_W-1:0]    in_time_ext;
    logic [IEXT_W-1:0]    in_id_ext;
    logic [LIDX_W-1:0]    cur_lane;
    logic [LST_W-1:0]     cur_word;
    logic [PTR_W-1:0]     cur_rp;
    logic [CNT_W-1:0]     cur_cnt;
    logic [SUM_W-1:0]     wp_sum;
    logic [PTR_W-1:0]     wp;
    logic [SUM_W-1:0]     rp_inc;
    logic [PTR_W-1:0]     rp_new;
    logic [TIME_BITS-1:0] rec_time;
    logic [ID_BITS-1:0]   rec_id;
    logic [LCMP_W-1:0]    best_lane_ext;
    logic [TEXT_W-1:0]    best_time_ext;
    logic [IEXT_W-1:0]    best_id_ext;

    kwtm_ram
    #(
        .WIDTH (LST_W),
        .DEPTH (LANES)
    )
    u_lane_state_ram
    (
        .clk   (clk),
        .we    (lst_we),
        .waddr (lst_waddr),
        .wdata (lst_wdata),
        .re    (lst_re),
        .raddr (lst_raddr),
        .rdata (lst_rdata)
    );

    kwtm_ram
    #(
        .WIDTH (REC_W),
        .DEPTH (STORE_DEPTH)
    )
    u_store_ram
    (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_lane_ext = LCMP_W'(in_data.lane);
    assign in_lane_ok  = (in_lane_ext < LCMP_W'(LANES));
    assign in_time_ext = TEXT_W'(in_data.timestamp);
    assign in_id_ext   = IEXT_W'(in_data.record_id);

    // A lane whose valid bit is clear has never been written and reads as empty.
    assign cur_lane = (state_reg == S_PUSH) ? req_lane_reg : p1_lane_reg;
    assign cur_word = lane_valid_reg[cur_lane] ? lst_rdata : '0;
    assign cur_rp   = cur_word[LST_W-1:CNT_W];
    assign cur_cnt  = cur_word[CNT_W-1:0];

    // Tail slot = head + count, wrapped once at the lane depth.
    assign wp_sum = SUM_W'(cur_rp) + SUM_W'(cur_cnt);
    always_comb
    begin
        if (wp_sum >= SUM_W'(LANE_DEPTH))
        begin
            wp = PTR_W'(wp_sum - SUM_W'(LANE_DEPTH));
        end
        else
        begin
            wp = wp_sum[PTR_W-1:0];
        end
    end

    assign rp_inc = SUM_W'(best_rp_reg) + SUM_W'(1);
    assign rp_new = (rp_inc == SUM_W'(LANE_DEPTH)) ? '0 : rp_inc[PTR_W-1:0];

    assign rec_time = store_rdata[REC_W-1:ID_BITS];
    assign rec_id   = store_rdata[ID_BITS-1:0];

    assign best_lane_ext = LCMP_W'(best_lane_reg);
    assign best_time_ext = TEXT_W'(best_time_reg);
    assign best_id_ext   = IEXT_W'(best_id_reg);

    always_comb
    begin
        state_next      = state_reg;
        lane_valid_next = lane_valid_reg;
        req_lane_next   = req_lane_reg;
        req_rec_next    = req_rec_reg;
        issue_cnt_next  = issue_cnt_reg;
        p1_vld_next     = 1'b0;
        p1_lane_next    = p1_lane_reg;
        p2_vld_next     = 1'b0;
        p2_lane_next    = p2_lane_reg;
        p2_rp_next      = p2_rp_reg;
        p2_cnt_next     = p2_cnt_reg;
        found_next      = found_reg;
        best_lane_next  = best_lane_reg;
        best_rp_next    = best_rp_reg;
        best_cnt_next   = best_cnt_reg;
        best_time_next  = best_time_reg;
        best_id_next    = best_id_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        lst_we      = 1'b0;
        lst_waddr   = req_lane_reg;
        lst_wdata   = {cur_rp, CNT_W'(cur_cnt + CNT_W'(1))};
        lst_re      = 1'b0;
        lst_raddr   = in_lane_ext[LIDX_W-1:0];
        store_we    = 1'b0;
        store_waddr = {req_lane_reg, wp};
        store_wdata = req_rec_reg;
        store_re    = 1'b0;
        store_raddr = {p1_lane_reg, cur_rp};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_lane_next = in_lane_ext[LIDX_W-1:0];
                    req_rec_next  = {in_time_ext[TIME_BITS-1:0], in_id_ext[ID_BITS-1:0]};
                    if (in_data.operation == OP_POP)
                    begin
                        issue_cnt_next = '0;
                        found_next     = 1'b0;
                        state_next     = S_SCAN;
                    end
                    else if (in_lane_ok)
                    begin
                        lst_re     = 1'b1;
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        res_status_next = ST_PUSH_DROP;
                        state_next      = S_RESULT;
                    end
                end
            end

            S_PUSH:
            begin
                if (cur_cnt >= CNT_W'(LANE_DEPTH))
                begin
                    res_status_next = ST_PUSH_DROP;
                end
                else
                begin
                    store_we                      = 1'b1;
                    lst_we                        = 1'b1;
                    lane_valid_next[req_lane_reg] = 1'b1;
                    res_status_next               = ST_PUSH_OK;
                end
                state_next = S_RESULT;
            end

            S_SCAN:
            begin
                // First stage: read the state of the next lane.
                if (issue_cnt_reg != ISS_W'(LANES))
                begin
                    lst_re         = 1'b1;
                    lst_raddr      = issue_cnt_reg[LIDX_W-1:0];
                    p1_vld_next    = 1'b1;
                    p1_lane_next   = issue_cnt_reg[LIDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + ISS_W'(1);
                end
                // Second stage: fetch the head record of a non-empty lane.
                if (p1_vld_reg && (cur_cnt != '0))
                begin
                    store_re     = 1'b1;
                    p2_vld_next  = 1'b1;
                    p2_lane_next = p1_lane_reg;
                    p2_rp_next   = cur_rp;
                    p2_cnt_next  = cur_cnt;
                end
                // Third stage: the shared comparator keeps only a strictly older head,
                // so the lowest lane wins a tie.
                if (p2_vld_reg && (!found_reg || (best_time_reg > rec_time)))
                begin
                    found_next     = 1'b1;
                    best_lane_next = p2_lane_reg;
                    best_rp_next   = p2_rp_reg;
                    best_cnt_next  = p2_cnt_reg;
                    best_time_next = rec_time;
                    best_id_next   = rec_id;
                end
                if ((issue_cnt_reg == ISS_W'(LANES)) && !p1_vld_reg && !p2_vld_reg)
                begin
                    state_next = S_POP_WR;
                end
            end

            S_POP_WR:
            begin
                if (found_reg)
                begin
                    lst_we          = 1'b1;
                    lst_waddr       = best_lane_reg;
                    lst_wdata       = {rp_new, CNT_W'(best_cnt_reg - CNT_W'(1))};
                    res_status_next = ST_POPPED;
                end
                else
                begin
                    res_status_next = ST_EMPTY;
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.status = res_status_reg;
                    if (res_status_reg == ST_POPPED)
                    begin
                        out_data_next.out_lane      = best_lane_ext[LANE_FIELD_W-1:0];
                        out_data_next.out_timestamp = best_time_ext[TIME_FIELD_W-1:0];
                        out_data_next.out_record_id = best_id_ext[ID_FIELD_W-1:0];
                    end
                    else
                    begin
                        out_data_next.out_lane      = '0;
                        out_data_next.out_timestamp = '0;
                        out_data_next.out_record_id = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lane_valid_reg <= '0;
            issue_cnt_reg  <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            res_status_reg <= ST_EMPTY;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lane_valid_reg <= lane_valid_next;
            issue_cnt_reg  <= issue_cnt_next;
            p1_vld_reg     <= p1_vld_next;
            p2_vld_reg     <= p2_vld_next;
            found_reg      <= found_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_lane_reg  <= req_lane_next;
        req_rec_reg   <= req_rec_next;
        p1_lane_reg   <= p1_lane_next;
        p2_lane_reg   <= p2_lane_next;
        p2_rp_reg     <= p2_rp_next;
        p2_cnt_reg    <= p2_cnt_next;
        best_lane_reg <= best_lane_next;
        best_rp_reg   <= best_rp_next;
        best_cnt_reg  <= best_cnt_next;
        best_time_reg <= best_time_next;
        best_id_reg   <= best_id_next;
        out_data_reg  <= out_data_next;
    end

    `KWTM_ASSERT_NEXT(a_one_beat_at_a_time, in_valid && in_ready, !in_ready,
        "input accepted while a beat is still in progress")

    `KWTM_ASSERT_IMPLY(a_pop_from_nonempty, (state_reg == S_POP_WR) && found_reg,
        best_cnt_reg != '0, "selected lane head has a zero fill count")

    `KWTM_ASSERT_IMPLY(a_result_from_final_state, $rose(out_valid_reg),
        $past(state_reg == S_RESULT), "result raised outside the result state")

endmodule
